>>> src/follow_the_leader_arm_selector_macros.svh
// Assertion macros shared by the arm selector RTL.
`ifndef FOLLOW_THE_LEADER_ARM_SELECTOR_MACROS_SVH
`define FOLLOW_THE_LEADER_ARM_SELECTOR_MACROS_SVH
`ifndef SYNTHESIS
// Consequent checked in the same cycle as the antecedent.
`define FTL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define FTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FTL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define FTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/ftl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ftl_pkg;

    localparam int MAX_ARMS  = 16;
    localparam int ARM_W     = 4;
    localparam int DATA_W    = 16;
    localparam int CNT_W     = 16;
    localparam int RF_W      = 16;
    localparam int CFG_W     = 5;
    localparam int TIE_W     = $clog2(MAX_ARMS + 1);
    localparam int NUM_W     = 32;
    localparam int DIV_STEPS = 17;
    localparam int LOOP_W    = 5;
    localparam int UPC_W     = 4;

    localparam logic signed [DATA_W-1:0] AVG_ONE    = 16'sd16384;
    localparam logic [CNT_W-1:0]         CNT_ONE    = 16'd1;
    localparam logic [CNT_W-1:0]         CNT_MAX    = 16'hFFFF;
    localparam logic [CFG_W-1:0]         ARMS_RESET = 5'd16;
    localparam logic [CFG_W-1:0]         ARMS_MAX   = CFG_W'(MAX_ARMS);
    localparam logic [CFG_W-1:0]         ARMS_MIN   = 5'd1;
    localparam logic                     KIND_REWARD = 1'b0;
    localparam logic                     KIND_CHOOSE = 1'b1;
    localparam logic [LOOP_W-1:0]        DIV_LOOP   = LOOP_W'(DIV_STEPS - 1);

    // microprogram addresses
    localparam logic [UPC_W-1:0] S_IDLE      = 4'd0;
    localparam logic [UPC_W-1:0] S_LOAD      = 4'd1;
    localparam logic [UPC_W-1:0] S_MUL       = 4'd2;
    localparam logic [UPC_W-1:0] S_ADD       = 4'd3;
    localparam logic [UPC_W-1:0] S_DIV_INIT  = 4'd4;
    localparam logic [UPC_W-1:0] S_DIV       = 4'd5;
    localparam logic [UPC_W-1:0] S_WRITE     = 4'd6;
    localparam logic [UPC_W-1:0] S_SCAN_INIT = 4'd7;
    localparam logic [UPC_W-1:0] S_SCAN      = 4'd8;
    localparam logic [UPC_W-1:0] S_PICK      = 4'd9;
    localparam logic [UPC_W-1:0] S_FIND      = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_ADD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_WRITE,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_PICK,
        OP_FIND
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_DISPATCH,
        C_SKIP_OUT,
        C_LOOP,
        C_STAY_LAST,
        C_STAY_FOUND
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
        logic             ld_loop;
    } t_ctrl;

    typedef struct packed {
        logic out_of_use;
        logic last;
        logic found;
    } t_stat;

    // control store
    function automatic t_ctrl ucode(input logic [UPC_W-1:0] addr);
        t_ctrl w;
        w = '{op: OP_NOP, cond: C_GOTO, target: S_IDLE, ld_loop: 1'b0};
        case (addr)
            S_IDLE:      w = '{op: OP_NOP,       cond: C_DISPATCH,   target: S_SCAN_INIT, ld_loop: 1'b0};
            S_LOAD:      w = '{op: OP_LOAD,      cond: C_SKIP_OUT,   target: S_IDLE,      ld_loop: 1'b0};
            S_MUL:       w = '{op: OP_MUL,       cond: C_NEXT,       target: S_IDLE,      ld_loop: 1'b0};
            S_ADD:       w = '{op: OP_ADD,       cond: C_NEXT,       target: S_IDLE,      ld_loop: 1'b0};
            S_DIV_INIT:  w = '{op: OP_DIV_INIT,  cond: C_NEXT,       target: S_IDLE,      ld_loop: 1'b1};
            S_DIV:       w = '{op: OP_DIV_STEP,  cond: C_LOOP,       target: S_DIV,       ld_loop: 1'b0};
            S_WRITE:     w = '{op: OP_WRITE,     cond: C_GOTO,       target: S_IDLE,      ld_loop: 1'b0};
            S_SCAN_INIT: w = '{op: OP_SCAN_INIT, cond: C_NEXT,       target: S_IDLE,      ld_loop: 1'b0};
            S_SCAN:      w = '{op: OP_SCAN,      cond: C_STAY_LAST,  target: S_IDLE,      ld_loop: 1'b0};
            S_PICK:      w = '{op: OP_PICK,      cond: C_NEXT,       target: S_IDLE,      ld_loop: 1'b0};
            S_FIND:      w = '{op: OP_FIND,      cond: C_STAY_FOUND, target: S_IDLE,      ld_loop: 1'b0};
            default:     w = '{op: OP_NOP,       cond: C_GOTO,       target: S_IDLE,      ld_loop: 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/ftl_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "follow_the_leader_arm_selector_macros.svh"

module ftl_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_kind,
    input  wire ftl_pkg::t_stat i_stat,
    output ftl_pkg::t_ctrl     o_ctrl,
    output logic               o_busy
);
    import ftl_pkg::*;

    logic [UPC_W-1:0]  r_upc;
    logic [UPC_W-1:0]  n_upc;
    logic [LOOP_W-1:0] r_loop;
    logic [LOOP_W-1:0] n_loop;
    t_ctrl             w;

    assign w      = ucode(r_upc);
    assign o_ctrl = w;
    assign o_busy = (r_upc != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc  <= S_IDLE;
            r_loop <= '0;
        end else begin
            r_upc  <= n_upc;
            r_loop <= n_loop;
        end
    end

    always_comb begin
        n_upc  = r_upc + 1'b1;
        n_loop = r_loop;
        if (w.ld_loop) begin
            n_loop = DIV_LOOP;
        end
        case (w.cond)
            C_NEXT: begin
                n_upc = r_upc + 1'b1;
            end
            C_GOTO: begin
                n_upc = w.target;
            end
            C_DISPATCH: begin
                if (!i_start) begin
                    n_upc = r_upc;
                end else if (i_kind == KIND_CHOOSE) begin
                    n_upc = w.target;
                end
            end
            C_SKIP_OUT: begin
                if (i_stat.out_of_use) begin
                    n_upc = w.target;
                end
            end
            C_LOOP: begin
                if (r_loop != '0) begin
                    n_upc  = w.target;
                    n_loop = r_loop - 1'b1;
                end
            end
            C_STAY_LAST: begin
                if (!i_stat.last) begin
                    n_upc = r_upc;
                end
            end
            C_STAY_FOUND: begin
                if (i_stat.found) begin
                    n_upc = w.target;
                end else begin
                    n_upc = r_upc;
                end
            end
            default: begin
                n_upc = S_IDLE;
            end
        endcase
    end

    // loop count only lives inside the divide loop
    `FTL_ASSERT_SAME(a_loop_in_div, i_clk, i_rst_n, r_loop != '0, r_upc == S_DIV, "loop count outside divide")

endmodule

`default_nettype wire

>>> src/ftl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "follow_the_leader_arm_selector_macros.svh"

module ftl_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [ftl_pkg::ARM_W-1:0]    i_arm,
    input  wire logic signed [ftl_pkg::DATA_W-1:0] i_reward,
    input  wire logic [ftl_pkg::RF_W-1:0]     i_random_fraction,
    input  wire logic                         i_cfg_we,
    input  wire logic [ftl_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire ftl_pkg::t_ctrl               i_ctrl,
    output ftl_pkg::t_stat                    o_stat,
    output logic                              o_valid,
    output logic [ftl_pkg::ARM_W-1:0]         o_chosen_arm,
    output logic signed [ftl_pkg::DATA_W-1:0] o_leader_average
);
    import ftl_pkg::*;

    // per-arm state
    logic signed [DATA_W-1:0] r_avg [MAX_ARMS];
    logic [CNT_W-1:0]         r_cnt [MAX_ARMS];
    logic [CFG_W-1:0]         r_arms_in_use;

    // latched item
    logic [ARM_W-1:0]         r_arm;
    logic signed [DATA_W-1:0] r_reward;
    logic [RF_W-1:0]          r_rf;

    // update path
    logic [CNT_W-1:0]         r_c;
    logic signed [DATA_W-1:0] r_a;
    logic signed [NUM_W-1:0]  r_prod;
    logic                     r_neg;
    logic [CNT_W-1:0]         r_rem;
    logic [NUM_W-1:0]         r_sh;

    // selection path
    logic [ARM_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_best;
    logic [TIE_W-1:0]         r_ties;
    logic [MAX_ARMS-1:0]      r_mask;
    logic [ARM_W-1:0]         r_pick;
    logic [ARM_W-1:0]         r_seen;

    logic                     r_o_valid;
    logic [ARM_W-1:0]         r_o_arm;
    logic signed [DATA_W-1:0] r_o_avg;

    logic [CFG_W-1:0]             n_act;
    logic [ARM_W-1:0]             rd_addr;
    logic signed [DATA_W-1:0]     rd_avg;
    logic [CNT_W-1:0]             rd_cnt;
    logic signed [CNT_W:0]        cm1;
    logic signed [NUM_W:0]        mul_full;
    logic [NUM_W-1:0]             mag;
    logic [CNT_W:0]               trial;
    logic                         ge;
    logic [DIV_STEPS:0]           qv;
    logic [MAX_ARMS-1:0]          idx_hot;
    logic [RF_W+TIE_W-1:0]        pick_prod;

    always_comb begin
        n_act = r_arms_in_use;
        if (r_arms_in_use == '0) begin
            n_act = ARMS_MIN;
        end else if (r_arms_in_use > ARMS_MAX) begin
            n_act = ARMS_MAX;
        end
    end

    assign rd_addr   = (i_ctrl.op == OP_SCAN) ? r_idx : r_arm;
    assign rd_avg    = r_avg[rd_addr];
    assign rd_cnt    = r_cnt[r_arm];
    assign cm1       = $signed({1'b0, r_c - CNT_ONE});
    assign mul_full  = cm1 * r_a;
    assign mag       = r_prod[NUM_W-1] ? NUM_W'(-r_prod) : NUM_W'(r_prod);
    assign trial     = {r_rem, r_sh[NUM_W-1]};
    assign ge        = (trial >= {1'b0, r_c});
    assign qv        = {1'b0, r_sh[DIV_STEPS-1:0]};
    assign idx_hot   = MAX_ARMS'(1) << r_idx;
    assign pick_prod = (RF_W+TIE_W)'(r_rf) * (RF_W+TIE_W)'(r_ties);

    assign o_stat = '{out_of_use: (CFG_W'(r_arm) >= n_act),
                      last:       (CFG_W'(r_idx) == (n_act - CFG_W'(1))),
                      found:      r_mask[r_idx] && (r_seen == r_pick)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ARMS; i++) begin
                r_avg[i] <= AVG_ONE;
                r_cnt[i] <= CNT_ONE;
            end
            r_arms_in_use <= ARMS_RESET;
            r_o_valid     <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_arms_in_use <= i_cfg_data;
            end
            case (i_ctrl.op)
                OP_WRITE: begin
                    r_avg[r_arm] <= DATA_W'(r_neg ? -qv : qv);
                    r_cnt[r_arm] <= r_c;
                end
                OP_FIND: begin
                    if (o_stat.found) begin
                        r_o_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload and working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_arm    <= i_arm;
            r_reward <= i_reward;
            r_rf     <= i_random_fraction;
        end
        case (i_ctrl.op)
            OP_LOAD: begin
                r_c <= (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
                r_a <= rd_avg;
            end
            OP_MUL: begin
                r_prod <= NUM_W'(mul_full);
            end
            OP_ADD: begin
                r_prod <= r_prod + NUM_W'(r_reward);
            end
            OP_DIV_INIT: begin
                r_neg <= r_prod[NUM_W-1];
                r_rem <= CNT_W'(mag[NUM_W-1:DIV_STEPS]);
                r_sh  <= mag << (NUM_W - DIV_STEPS);
            end
            OP_DIV_STEP: begin
                r_rem <= ge ? CNT_W'(trial - {1'b0, r_c}) : CNT_W'(trial);
                r_sh  <= {r_sh[NUM_W-2:0], ge};
            end
            OP_SCAN_INIT: begin
                r_idx  <= '0;
                r_ties <= '0;
                r_mask <= '0;
            end
            OP_SCAN: begin
                if ((r_ties == '0) || (rd_avg > r_best)) begin
                    r_best <= rd_avg;
                    r_ties <= TIE_W'(1);
                    r_mask <= idx_hot;
                end else if (rd_avg == r_best) begin
                    r_ties <= r_ties + 1'b1;
                    r_mask <= r_mask | idx_hot;
                end
                r_idx <= r_idx + 1'b1;
            end
            OP_PICK: begin
                r_pick <= pick_prod[RF_W +: ARM_W];
                r_idx  <= '0;
                r_seen <= '0;
            end
            OP_FIND: begin
                if (o_stat.found) begin
                    r_o_arm <= r_idx;
                    r_o_avg <= r_best;
                end else begin
                    if (r_mask[r_idx]) begin
                        r_seen <= r_seen + 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid          = r_o_valid;
    assign o_chosen_arm     = r_o_arm;
    assign o_leader_average = r_o_avg;

    // the reported arm is always one of the tied leaders
    `FTL_ASSERT_SAME(a_chosen_tied, i_clk, i_rst_n, r_o_valid, r_mask[r_o_arm], "chosen arm not a leader")

endmodule

`default_nettype wire

>>> src/follow_the_leader_arm_selector.sv
// Follow-the-leader arm selector (greedy bandit), microcoded.
// Command channel: drive kind/arm/reward/random_fraction with start; the beat
// is taken at a clock edge where start is high and busy is low.
//  - Reward beat (kind 0): raises the arm's pull count (saturating) and folds
//    the reward into its running average. No result. Busy while it steps through
//    load, multiply, add, divide setup, 17 restoring divide steps, write-back.
//    A reward for an arm outside the arms in use is dropped at the load step.
//  - Choose beat (kind 1): one scan over the n arms in use finds the leader
//    average and the tie set, then a second walk picks the tied arm selected
//    by random_fraction. The result beat (o_valid for one cycle with
//    o_chosen_arm and o_leader_average) is registered when that walk reaches
//    the chosen arm; busy drops in the cycle that the beat is shown.
// Rate is set by the single shared datapath stepped by the microprogram: one
// arm or one quotient bit per cycle.
// Configuration: i_cfg_valid/o_cfg_ready write arms_in_use (ready is always
// high); write it only while busy is low and no result is pending.
// The receiver cannot stall: each result beat is shown for one cycle only.
// Reset (i_rst_n low, synchronous): all averages 1.0, counts 1, 16 arms.
`timescale 1ns / 1ps
`default_nettype none
`include "follow_the_leader_arm_selector_macros.svh"

module follow_the_leader_arm_selector (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_kind,
    input  wire logic [ftl_pkg::ARM_W-1:0]         i_arm,
    input  wire logic signed [ftl_pkg::DATA_W-1:0] i_reward,
    input  wire logic [ftl_pkg::RF_W-1:0]          i_random_fraction,
    // result strobe
    output logic                                   o_valid,
    output logic [ftl_pkg::ARM_W-1:0]              o_chosen_arm,
    output logic signed [ftl_pkg::DATA_W-1:0]      o_leader_average,
    // configuration write
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ftl_pkg::CFG_W-1:0]         i_cfg_data
);
    import ftl_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  accept;
    logic  cfg_we;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // sequencer: step counter, loop counter and control store
    ftl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    // datapath: arm state, multiply/divide, scan and pick
    ftl_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_arm             (i_arm),
        .i_reward          (i_reward),
        .i_random_fraction (i_random_fraction),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_ctrl            (ctrl),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_chosen_arm      (o_chosen_arm),
        .o_leader_average  (o_leader_average)
    );

    // a result follows a busy cycle, never an idle one
    `FTL_ASSERT_SAME(a_result_after_busy, i_clk, i_rst_n, o_valid, $past(busy), "result without work")
    // a reward beat never produces a result on the next cycle
    `FTL_ASSERT_NEXT(a_reward_silent, i_clk, i_rst_n, accept && (i_kind == KIND_REWARD), !o_valid, "result after reward")

endmodule

`default_nettype wire
